// ===== design/mbe_pkg.sv =====
// Shared types and constants of the escape-time iteration block.
package mbe_pkg;

    localparam int C_W       = 32;  // width of one component of c
    localparam int CNT_W     = 10;  // iteration counter and limit width
    localparam int LIMB_W    = 32;  // operand slice of the shared multiplier
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_BELOW = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] MAX_ITER_RST   = CNT_W'(200);
    localparam logic [CNT_W-1:0] DROP_BELOW_RST = CNT_W'(0);

    typedef struct packed {
        logic signed [C_W-1:0] c_real;
        logic signed [C_W-1:0] c_imag;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] iterations;
        logic             shape_rejected;
        logic             escaped;
        logic             counted;
    } t_out;

    typedef struct packed {
        logic start;
        logic wide;
    } t_mul_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CI2,
        S_AA,
        S_PSUM,
        S_PQ,
        S_BB,
        S_CHECK,
        S_XY,
        S_XX,
        S_YY,
        S_DONE
    } t_state;

endpackage

// ===== design/mbe_mul.sv =====
// Shared signed multiplier built from 32 by 32 partial products over several cycles.
module mbe_mul
    import mbe_pkg::*;
#(
    parameter int OW       = 38,
    parameter int NARROW_W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mul_req            i_req,
    input  logic signed [OW:0]  i_a,
    input  logic signed [OW:0]  i_b,
    output logic                o_done,
    output logic signed [2*OW:0] o_prod
);

    localparam int   OPAD      = 2 * LIMB_W;
    localparam int   PW        = 2 * OW + 1;
    localparam logic NARROW_OK = (NARROW_W <= LIMB_W) ? 1'b1 : 1'b0;

    logic                 r_busy;
    logic [1:0]           r_step;
    logic [1:0]           r_last;
    logic                 r_ppv;
    logic                 r_done;
    logic [OPAD-1:0]      r_ma;
    logic [OPAD-1:0]      r_mb;
    logic                 r_neg;
    logic [2*LIMB_W-1:0]  r_pp;
    logic [1:0]           r_sh;
    logic                 r_pplast;
    logic signed [PW-1:0] r_acc;

    logic signed [OW:0]   w_abs_a;
    logic signed [OW:0]   w_abs_b;
    logic [LIMB_W-1:0]    w_la;
    logic [LIMB_W-1:0]    w_lb;
    logic [PW-1:0]        w_term;

    assign w_abs_a = i_a[OW] ? -i_a : i_a;
    assign w_abs_b = i_b[OW] ? -i_b : i_b;

    // step bit 0 picks the slice of a, bit 1 the slice of b
    assign w_la = r_step[0] ? r_ma[OPAD-1:LIMB_W] : r_ma[LIMB_W-1:0];
    assign w_lb = r_step[1] ? r_mb[OPAD-1:LIMB_W] : r_mb[LIMB_W-1:0];

    always_comb begin
        case (r_sh)
            2'd0:    w_term = PW'(r_pp);
            2'd1:    w_term = PW'(r_pp) << LIMB_W;
            default: w_term = PW'(r_pp) << (2 * LIMB_W);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
            r_last <= 2'd0;
        end else begin
            r_done <= r_ppv & r_pplast;
            r_ppv  <= r_busy;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_last <= (i_req.wide || !NARROW_OK) ? 2'd3 : 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == r_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= {{(OPAD-OW){1'b0}}, w_abs_a[OW-1:0]};
            r_mb  <= {{(OPAD-OW){1'b0}}, w_abs_b[OW-1:0]};
            r_neg <= i_a[OW] ^ i_b[OW];
            r_acc <= '0;
        end else if (r_ppv) begin
            // fold the sign in as the slices arrive
            r_acc <= r_neg ? (r_acc - $signed(w_term)) : (r_acc + $signed(w_term));
        end
        if (r_busy) begin
            r_pp     <= w_la * w_lb;
            r_sh     <= {1'b0, r_step[0]} + {1'b0, r_step[1]};
            r_pplast <= (r_step == r_last);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== design/mandelbrot_escape_iteration.sv =====
// Escape-time iteration with cardioid and bulb pre-check; top level.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one point c as
// two signed fixed-point components with FRAC_BITS fraction bits. Output
// channel (o_out_valid / i_out_ready / o_out_data) returns one item per
// point: iteration count and the shape_rejected, escaped and counted flags.
// The configuration channel writes max_iter (index 0) and drop_below
// (index 1); other indexes are ignored. It is always ready.
// One shared multiplier does all the work under a small sequencer: a wide
// product uses four 32 by 32 slices, an iteration product a single slice
// while FRAC_BITS is at most 29 and four slices above that.
// A point inside the cardioid or the bulb finishes without iterating.
// One point is in flight; ready returns once the result has moved to the
// output register.
// A result waiting on a stalled receiver holds in the output register; a
// further point is still taken and worked on, and its result waits in the
// sequencer until the output register frees.
// Reset: synchronous, active low; max_iter returns to 200, drop_below to 0,
// and any point or result in flight is dropped.
module mandelbrot_escape_iteration
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    // Magnitude bound of a = c_real - 1/4 (and of c_imag)
    localparam int AW  = (FRAC_BITS - 2 > C_W - 1) ? FRAC_BITS - 1 : C_W;
    // Magnitude width of z components and of b = c_real + 1
    localparam int MW  = ((FRAC_BITS + 2 > C_W - 1) ? FRAC_BITS + 2 : C_W - 1) + 1;
    // Magnitude width of p and p + a in the cardioid test
    localparam int QW  = ((2*AW + 1 - FRAC_BITS > AW) ? 2*AW + 1 - FRAC_BITS : AW) + 1;
    localparam int OW  = (MW > QW) ? MW : QW;
    localparam int OPW = OW + 1;
    localparam int PW  = 2 * OW + 1;
    localparam int SW  = PW + 1;

    localparam logic signed [OPW-1:0] K_QUARTER = {{(OPW-1){1'b0}}, 1'b1} << (FRAC_BITS - 2);
    localparam logic signed [OPW-1:0] K_ONE     = {{(OPW-1){1'b0}}, 1'b1} << FRAC_BITS;

    t_state r_state;
    t_state n_state;
    logic   r_go;
    logic   r_out_valid;
    t_out   r_out_data;
    t_out   r_res;

    logic [CNT_W-1:0] r_max_iter;
    logic [CNT_W-1:0] r_drop_below;
    logic [CNT_W-1:0] r_iter;

    logic signed [C_W-1:0] r_cr;
    logic signed [C_W-1:0] r_ci;
    logic signed [OPW-1:0] r_a;
    logic signed [OPW-1:0] r_b;
    logic signed [OPW-1:0] r_p;
    logic signed [OPW-1:0] r_q;
    logic signed [OPW-1:0] r_x;
    logic signed [OPW-1:0] r_y;
    logic signed [PW-1:0]  r_ci2;
    logic signed [PW-1:0]  r_x2;
    logic signed [PW-1:0]  r_y2;
    logic signed [PW-1:0]  r_d;

    t_mul_req              w_mul_req;
    logic signed [OPW-1:0] w_mul_a;
    logic signed [OPW-1:0] w_mul_b;
    logic                  w_mul_done;
    logic signed [PW-1:0]  w_prod;

    logic                  w_in_ready;
    logic                  w_out_free;
    logic                  w_next_mul;
    logic signed [OPW-1:0] w_in_cr;
    logic signed [OPW-1:0] w_cr_x;
    logic signed [OPW-1:0] w_ci_x;
    logic signed [SW-1:0]  w_pc;
    logic signed [SW-1:0]  w_pc_sh;
    logic signed [PW+1:0]  w_lhs;
    logic signed [PW+1:0]  w_ci2_l;
    logic                  w_in_cardioid;
    logic                  w_in_bulb;
    logic signed [SW-1:0]  w_sum;
    logic                  w_below4;
    logic                  w_iter_lt;
    logic                  w_go_on;
    logic signed [PW-1:0]  w_diff;
    logic signed [PW-1:0]  w_xy_sh;
    logic signed [PW-1:0]  w_d_sh;
    logic signed [OPW-1:0] n_x;
    logic signed [OPW-1:0] n_y;
    logic signed [OPW-1:0] n_p;

    mbe_mul #(
        .OW       (OW),
        .NARROW_W (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // ---------------------------------------------------------------
    // Datapath arithmetic around the shared multiplier
    // ---------------------------------------------------------------
    assign w_in_cr = {{(OPW-C_W){i_in_data.c_real[C_W-1]}}, i_in_data.c_real};
    assign w_cr_x  = {{(OPW-C_W){r_cr[C_W-1]}}, r_cr};
    assign w_ci_x  = {{(OPW-C_W){r_ci[C_W-1]}}, r_ci};

    // product plus c_imag squared: serves p in the cardioid test and the bulb test
    assign w_pc    = {w_prod[PW-1], w_prod} + {r_ci2[PW-1], r_ci2};
    assign w_pc_sh = w_pc >>> FRAC_BITS;
    assign n_p     = w_pc_sh[OPW-1:0];

    // cardioid: 4*p*(p + a) < c_imag^2
    assign w_lhs         = {w_prod, 2'b00};
    assign w_ci2_l       = {{2{r_ci2[PW-1]}}, r_ci2};
    assign w_in_cardioid = (w_lhs < w_ci2_l);
    // bulb: (c_real + 1)^2 + c_imag^2 below 1/16; the sum is never negative
    assign w_in_bulb     = ~|w_pc[SW-1:2*FRAC_BITS-4];

    // escape test: x^2 + y^2 below 4
    assign w_sum     = {r_x2[PW-1], r_x2} + {r_y2[PW-1], r_y2};
    assign w_below4  = ~|w_sum[SW-1:2*FRAC_BITS+2];
    assign w_iter_lt = (r_iter < r_max_iter);
    assign w_go_on   = w_below4 && w_iter_lt;
    assign w_diff    = r_x2 - r_y2;

    // new z: floor of the exact products, then add c
    assign w_xy_sh = w_prod >>> (FRAC_BITS - 1);
    assign w_d_sh  = r_d >>> FRAC_BITS;
    assign n_y     = w_xy_sh[OPW-1:0] + w_ci_x;
    assign n_x     = w_d_sh[OPW-1:0] + w_cr_x;

    assign w_out_free = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CI2;
                end
            end
            S_CI2: begin
                if (w_mul_done) begin
                    n_state = S_AA;
                end
            end
            S_AA: begin
                if (w_mul_done) begin
                    n_state = S_PSUM;
                end
            end
            S_PSUM: begin
                n_state = S_PQ;
            end
            S_PQ: begin
                if (w_mul_done) begin
                    n_state = w_in_cardioid ? S_DONE : S_BB;
                end
            end
            S_BB: begin
                if (w_mul_done) begin
                    n_state = w_in_bulb ? S_DONE : S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_go_on ? S_XY : S_DONE;
            end
            S_XY: begin
                if (w_mul_done) begin
                    n_state = S_XX;
                end
            end
            S_XX: begin
                if (w_mul_done) begin
                    n_state = S_YY;
                end
            end
            S_YY: begin
                if (w_mul_done) begin
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs (multiplier operands and request, input ready)
    // ---------------------------------------------------------------
    always_comb begin
        w_mul_req.start = r_go;
        w_mul_req.wide  = 1'b0;
        w_mul_a         = r_x;
        w_mul_b         = r_y;
        w_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_CI2: begin
                w_mul_req.wide = 1'b1;
                w_mul_a        = w_ci_x;
                w_mul_b        = w_ci_x;
            end
            S_AA: begin
                w_mul_req.wide = 1'b1;
                w_mul_a        = r_a;
                w_mul_b        = r_a;
            end
            S_PQ: begin
                w_mul_req.wide = 1'b1;
                w_mul_a        = r_p;
                w_mul_b        = r_q;
            end
            S_BB: begin
                w_mul_req.wide = 1'b1;
                w_mul_a        = r_b;
                w_mul_b        = r_b;
            end
            S_XX: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
            S_YY: begin
                w_mul_a = r_y;
                w_mul_b = r_y;
            end
            default: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
        endcase
    end

    // issue a product in the first cycle of every multiply state
    assign w_next_mul = (n_state == S_CI2) || (n_state == S_AA) || (n_state == S_PQ) ||
                        (n_state == S_BB)  || (n_state == S_XY) || (n_state == S_XX) ||
                        (n_state == S_YY);

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_go         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_iter   <= MAX_ITER_RST;
            r_drop_below <= DROP_BELOW_RST;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state) && w_next_mul;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_ITER:   r_max_iter   <= i_cfg_data;
                    CFG_DROP_BELOW: r_drop_below <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_cr <= i_in_data.c_real;
                    r_ci <= i_in_data.c_imag;
                    r_a  <= w_in_cr - K_QUARTER;
                    r_b  <= w_in_cr + K_ONE;
                end
            end
            S_CI2: begin
                if (w_mul_done) begin
                    r_ci2 <= w_prod;
                end
            end
            S_AA: begin
                if (w_mul_done) begin
                    r_p <= n_p;
                end
            end
            S_PSUM: begin
                r_q <= r_p + r_a;
            end
            S_PQ: begin
                if (w_mul_done) begin
                    r_res.iterations     <= '0;
                    r_res.shape_rejected <= 1'b1;
                    r_res.escaped        <= 1'b0;
                    r_res.counted        <= 1'b0;
                end
            end
            S_BB: begin
                if (w_mul_done) begin
                    // start the orbit at zero
                    r_x    <= '0;
                    r_y    <= '0;
                    r_x2   <= '0;
                    r_y2   <= '0;
                    r_iter <= '0;
                end
            end
            S_CHECK: begin
                r_d                  <= w_diff;
                r_res.iterations     <= r_iter;
                r_res.shape_rejected <= 1'b0;
                r_res.escaped        <= w_iter_lt;
                r_res.counted        <= w_iter_lt && (r_iter > r_drop_below);
            end
            S_XY: begin
                if (w_mul_done) begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_iter <= r_iter + CNT_W'(1);
                end
            end
            S_XX: begin
                if (w_mul_done) begin
                    r_x2 <= w_prod;
                end
            end
            S_YY: begin
                if (w_mul_done) begin
                    r_y2 <= w_prod;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_data <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the escape-time iteration block: directed and random points.
module tb_top
    import mbe_pkg::*;
;

    localparam int FRAC  = 28;
    localparam int Q_ONE = 1 << FRAC;
    localparam logic [C_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [C_W-1:0] Q_MIN = 32'h8000_0000;

    typedef logic signed [63:0]  t_fix;
    typedef logic signed [127:0] t_wide;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    // Our own copy of the two limit registers, updated when a write is taken.
    logic [CNT_W-1:0] lim_iter = MAX_ITER_RST;
    logic [CNT_W-1:0] drop_lim = DROP_BELOW_RST;

    t_in  pending_points[$];     // points waiting to be offered
    t_out expected_results[$];   // predictions for points already taken

    bit     holding;             // the driver has a point on the bus
    int     gap_left;
    int     stall_left;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     calm;                // no idling on either side
    int     fail_count;
    int     queued_total;
    longint cycle_no;
    longint worst_cycles;
    t_out   seen;
    t_out   want;

    mandelbrot_escape_iteration #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Escape-time predictor: exact 128-bit products, floor on the way back
    // ------------------------------------------------------------------
    function automatic t_wide mul_wide(input t_fix a, input t_fix b);
        t_wide wa;
        t_wide wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // Arithmetic shift keeps the rounding towards minus infinity.
    function automatic t_fix floor_q(input t_wide v);
        t_wide s;
        s = v >>> FRAC;
        return s[63:0];
    endfunction

    // Main cardioid via p = |c - 1/4|^2 floored, then the period-2 bulb.
    function automatic bit in_main_shapes(input t_fix cr, input t_fix ci);
        t_fix  a;
        t_fix  b;
        t_fix  p;
        t_wide ci2;
        t_wide lhs;
        a   = cr - (64'sd1 <<< (FRAC - 2));
        b   = cr + (64'sd1 <<< FRAC);
        ci2 = mul_wide(ci, ci);
        p   = floor_q(mul_wide(a, a) + ci2);
        lhs = mul_wide(p, p + a) <<< 2;
        if (lhs < ci2) return 1'b1;
        return (mul_wide(b, b) + ci2) < (128'sd1 <<< (2 * FRAC - 4));
    endfunction

    function automatic t_out escape_time(input t_in c);
        t_fix  cr;
        t_fix  ci;
        t_fix  x;
        t_fix  y;
        t_fix  nx;
        t_fix  ny;
        t_wide x2;
        t_wide y2;
        t_wide xy;
        int    n;
        t_out  r;
        cr = {{(64 - C_W){c.c_real[C_W-1]}}, c.c_real};
        ci = {{(64 - C_W){c.c_imag[C_W-1]}}, c.c_imag};
        r  = '0;
        if (in_main_shapes(cr, ci)) begin
            r.shape_rejected = 1'b1;
            return r;
        end
        x  = '0;
        y  = '0;
        x2 = '0;
        y2 = '0;
        n  = 0;
        while (x2 + y2 < (128'sd1 <<< (2 * FRAC + 2)) && n < int'(lim_iter)) begin
            xy = mul_wide(x, y);
            ny = floor_q(xy + xy) + ci;
            nx = floor_q(x2 - y2) + cr;
            x  = nx;
            y  = ny;
            x2 = mul_wide(x, x);
            y2 = mul_wide(y, y);
            n++;
        end
        r.iterations = CNT_W'(n);
        r.escaped    = n < int'(lim_iter);
        r.counted    = r.escaped && n > int'(drop_lim);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Point generation
    // ------------------------------------------------------------------
    function automatic t_in pt(input logic [C_W-1:0] re, input logic [C_W-1:0] im);
        t_in v;
        v.c_real = re;
        v.c_imag = im;
        return v;
    endfunction

    function automatic int to_q(input real r);
        return $rtoi(r * Q_ONE);
    endfunction

    function automatic t_in mk(input real re, input real im);
        return pt(to_q(re), to_q(im));
    endfunction

    // Offset of random magnitude, from a few LSBs up to a sizeable step.
    function automatic int jitter();
        int w;
        w = 1 << $urandom_range(0, 24);
        return int'($urandom_range(0, 2 * w)) - w;
    endfunction

    function automatic int span(input int lo, input int width);
        return lo + int'($urandom_range(0, width));
    endfunction

    function automatic logic [C_W-1:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            4:       return C_W'(1);
            default: return C_W'(2 * Q_ONE);
        endcase
    endfunction

    // Mix of wild points, the box around the set, and points hugging the
    // cardioid and bulb rims where the shape test is decided by the last bit.
    function automatic t_in pick_point();
        real th;
        th = $urandom_range(0, 62831) / 10000.0;
        case ($urandom_range(0, 9))
            0, 1:    return pt($urandom, $urandom);
            2, 3, 4: return pt(span(-2 * Q_ONE - Q_ONE / 4, 3 * Q_ONE),
                               span(-3 * Q_ONE / 2, 3 * Q_ONE));
            5, 6:    return pt(to_q(0.5 * $cos(th) - 0.25 * $cos(2.0 * th)) + jitter(),
                               to_q(0.5 * $sin(th) - 0.25 * $sin(2.0 * th)) + jitter());
            7:       return pt(to_q(-1.0 + 0.25 * $cos(th)) + jitter(),
                               to_q(0.25 * $sin(th)) + jitter());
            8:       return pt(span(-2 * Q_ONE - Q_ONE / 4, 3 * Q_ONE), '0);
            default: return pt(corner_word(), corner_word());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued points, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holding  = 1'b0;
            gap_left = 0;
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results = {expected_results, escape_time(i_in_data)};
                holding = 1'b0;
            end
            // Only touch valid when the bus is free, so it never dips between
            // back-to-back items.
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_points.size() > 0 && !calm &&
                             $urandom_range(0, 99) < send_idle_pct) begin
                    gap_left = $urandom_range(0, 3);
                end else if (pending_points.size() > 0) begin
                    i_in_data <= pending_points.pop_front();
                    holding = 1'b1;
                end
                i_in_valid <= holding;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the result side in bursts, check every result taken
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int exp_val);
        fail_count++;
        $display("cycle %0d: %s got %0d, wanted %0d", cycle_no, what, got, exp_val);
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            seen = o_out_data;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing outstanding, iterations",
                                seen.iterations, 0);
            end else begin
                want = expected_results.pop_front();
                if (seen.iterations !== want.iterations)
                    report_mismatch("iterations", seen.iterations, want.iterations);
                if (seen.shape_rejected !== want.shape_rejected)
                    report_mismatch("shape_rejected", seen.shape_rejected,
                                    want.shape_rejected);
                if (seen.escaped !== want.escaped)
                    report_mismatch("escaped", seen.escaped, want.escaped);
                if (seen.counted !== want.counted)
                    report_mismatch("counted", seen.counted, want.counted);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < recv_stall_pct) begin
            stall_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: the limit grows with the slowest correct run of what is queued.
    always @(posedge i_clk) begin
        cycle_no++;
        if (cycle_no > 4 * worst_cycles + 100000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    task automatic queue_point(input t_in p);
        pending_points = {pending_points, p};
        queued_total++;
        worst_cycles += 60 + 13 * longint'(lim_iter);
    endtask

    // Hold until every point has been taken and every result returned.
    task automatic drain();
        while (pending_points.size() > 0 || holding || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MAX_ITER)
            lim_iter = val;
        else if (idx == CFG_DROP_BELOW)
            drop_lim = val;
        i_cfg_valid <= 1'b0;
        worst_cycles += 10;
        @(posedge i_clk);
    endtask

    // Indexes past the register list must leave both limits untouched.
    task automatic write_unused();
        for (int k = int'(CFG_DROP_BELOW) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CNT_W'($urandom));
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] lim, input logic [CNT_W-1:0] drop);
        drain();
        write_reg(CFG_MAX_ITER, lim);
        write_reg(CFG_DROP_BELOW, drop);
    endtask

    task automatic pick_pressure();
        case ($urandom_range(0, 2))
            0:       send_idle_pct = 0;
            1:       send_idle_pct = 10;
            default: send_idle_pct = 30;
        endcase
        case ($urandom_range(0, 3))
            0:       recv_stall_pct = 0;
            1:       recv_stall_pct = 10;
            2:       recv_stall_pct = 30;
            default: recv_stall_pct = 85;   // chained stalls back the result up
        endcase
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++)
            queue_point(pick_point());
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [CNT_W-1:0] lim;
        fail_count     = 0;
        queued_total   = 0;
        cycle_no       = 0;
        worst_cycles   = 0;
        stall_left     = 0;
        calm           = 1'b0;
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        lim_iter = MAX_ITER_RST;
        drop_lim = DROP_BELOW_RST;

        // Directed points under the reset limits.
        queue_point(mk(0.0, 0.0));        // centre of the cardioid
        queue_point(mk(-1.0, 0.0));       // centre of the period-2 bulb
        queue_point(mk(0.25, 0.0));       // cusp: on the rim, never rejected
        queue_point(mk(-0.75, 0.0));      // neck between cardioid and bulb
        queue_point(mk(-1.25, 0.0));      // left rim of the bulb
        queue_point(mk(0.0, 1.0));
        queue_point(mk(-2.0, 0.0));       // |z|^2 lands on exactly four
        queue_point(mk(2.0, 0.0));
        queue_point(mk(1.0, 0.0));
        queue_point(mk(0.3, 0.0));
        queue_point(mk(-0.12, 0.75));     // inside a period-3 bulb
        queue_point(mk(-1.75, 0.0));
        queue_point(pt(Q_MAX, Q_MAX));
        queue_point(pt(Q_MIN, Q_MIN));
        queue_point(pt(Q_MAX, Q_MIN));
        queue_point(pt(Q_MIN, Q_MAX));
        queue_point(pt('0, Q_MIN));
        queue_point(pt(Q_MIN, '0));
        queue_point(pt('1, '1));

        // Top of both ranges, then check that spare indexes are ignored.
        set_limits('1, '1);
        write_unused();
        queue_random(8);

        // Zero limit: nothing iterates, nothing escapes.
        set_limits('0, '0);
        queue_random(20);

        set_limits(CNT_W'(1), '0);
        queue_random(40);

        set_limits('1, '0);
        queue_random(8);

        // Random limits, mostly small to keep the run short. Each new setting
        // also makes the sender wait for every outstanding result.
        while (queued_total < 1340) begin
            if ($urandom_range(0, 4) == 0)
                lim = CNT_W'($urandom_range(49, 160));
            else
                lim = CNT_W'($urandom_range(1, 48));
            set_limits(lim, CNT_W'($urandom_range(0, int'(lim) + 2)));
            if ($urandom_range(0, 3) == 0)
                write_unused();
            pick_pressure();
            queue_random($urandom_range(60, 120));
        end

        // Closing stretch with both sides flat out.
        calm = 1'b1;
        set_limits(CNT_W'(30), CNT_W'(5));
        queue_random(60);

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mbe_pkg.sv
design/mbe_mul.sv
design/mandelbrot_escape_iteration.sv
test/tb_top.sv
